### sv/bdq_pkg.sv
package bdq_pkg;

  // store geometry (DEPTH is a power of two, so ring slots wrap by truncation)
  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int WORD_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 3;
  localparam int OP_W     = 3;

  // request modes
  localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE_HEAD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TAKE_TAIL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLOSE     = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLOSED   = 3'd4;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_TAKE   = 3'd3;
  localparam logic [OP_W-1:0] OP_SWEEP  = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;
  localparam logic [OP_W-1:0] OP_CLOSE  = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic                req_load;
    logic [OP_W-1:0]     op;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              closed;
    logic              full;
    logic              empty;
    logic              found;
    logic              sweep_done;
    logic              out_free;
    logic [MODE_W-1:0] mode;
  } sts_t;

endpackage

### sv/bdq_in_if.sv
interface bdq_in_if;
  import bdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [WORD_W-1:0] item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink (input valid, input mode, input item_value, output ready);
endinterface

### sv/bdq_out_if.sv
interface bdq_out_if;
  import bdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   item_out;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, output item_out, output status, output entry_count,
                  input ready);
  modport sink (input valid, input item_out, input status, input entry_count,
                output ready);
endinterface

### sv/bdq_cfg_if.sv
interface bdq_cfg_if;
  import bdq_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] max_entries;

  modport source (output valid, output max_entries, input ready);
  modport sink (input valid, input max_entries, output ready);
endinterface

### sv/bdq_ctrl.sv
module bdq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bdq_pkg::sts_t sts,
  output bdq_pkg::cmd_t cmd
);
  import bdq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.req_load   = 1'b0;
    cmd.op         = OP_NONE;
    cmd.res_load   = 1'b0;
    cmd.res_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.closed) begin
          if (sts.out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_CLOSED;
            state_nxt      = S_IDLE;
          end
        end else begin
          case (sts.mode)
            MODE_APPEND: begin
              if (sts.out_free) begin
                cmd.res_load = 1'b1;
                state_nxt    = S_IDLE;
                if (sts.full) begin
                  cmd.res_status = ST_FULL;
                end else begin
                  cmd.op = OP_APPEND;
                end
              end
            end
            MODE_TAKE_HEAD, MODE_TAKE_TAIL: begin
              if (sts.empty) begin
                if (sts.out_free) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_EMPTY;
                  state_nxt      = S_IDLE;
                end
              end else begin
                cmd.op    = OP_READ;
                state_nxt = S_READ;
              end
            end
            MODE_REMOVE: begin
              state_nxt = S_SWEEP;
            end
            MODE_CLOSE: begin
              if (sts.out_free) begin
                cmd.op       = OP_CLOSE;
                cmd.res_load = 1'b1;
                state_nxt    = S_IDLE;
              end
            end
            default: begin
              // undefined modes are answered ok and change nothing
              if (sts.out_free) begin
                cmd.res_load = 1'b1;
                state_nxt    = S_IDLE;
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.op       = OP_TAKE;
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sts.sweep_done && sts.out_free) begin
          cmd.op         = OP_REMOVE;
          cmd.res_load   = 1'b1;
          cmd.res_status = sts.found ? ST_OK : ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op = OP_SWEEP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### sv/bdq_datapath.sv
module bdq_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bdq_pkg::cmd_t                 cmd,
  output bdq_pkg::sts_t                 sts,
  input  logic [bdq_pkg::MODE_W-1:0]    in_mode,
  input  logic [bdq_pkg::WORD_W-1:0]    in_value,
  input  logic                          cfg_we,
  input  logic [bdq_pkg::CNT_W-1:0]     cfg_max,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bdq_pkg::WORD_W-1:0]    out_item,
  output logic [bdq_pkg::STATUS_W-1:0]  out_status,
  output logic [bdq_pkg::CNT_W-1:0]     out_count
);
  import bdq_pkg::*;

  logic [WORD_W-1:0]   entry_mem [DEPTH];
  logic [WORD_W-1:0]   rdata_r;

  logic [MODE_W-1:0]   mode_r;
  logic [WORD_W-1:0]   word_r;
  logic [CNT_W-1:0]    max_r;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                closed_r, closed_nxt;

  logic [CNT_W-1:0]    ptr_r;
  logic [IDX_W-1:0]    tag_r;
  logic                rd_vld_r;
  logic                found_r;

  logic                out_valid_r;
  logic [WORD_W-1:0]   out_item_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CNT_W-1:0]    out_count_r;

  logic                mem_re, mem_we;
  logic [IDX_W-1:0]    raddr, waddr;
  logic [WORD_W-1:0]   wdata;
  logic                sweep_rd;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;
  assign sweep_rd = (cmd.op == OP_SWEEP) && (ptr_r < count_r);

  // status to the controller
  always_comb begin
    sts.closed     = closed_r;
    sts.full       = (count_r >= max_r) || (count_r >= CNT_W'(DEPTH));
    sts.empty      = (count_r == '0);
    sts.found      = found_r;
    sts.sweep_done = (ptr_r == count_r) && !rd_vld_r;
    sts.out_free   = out_free;
    sts.mode       = mode_r;
  end

  // memory addressing
  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    raddr  = head_r + ptr_r[IDX_W-1:0];
    waddr  = head_r + tag_r - 1'b1;
    wdata  = rdata_r;
    case (cmd.op)
      OP_APPEND: begin
        mem_we = 1'b1;
        waddr  = head_r + count_r[IDX_W-1:0];
        wdata  = word_r;
      end
      OP_READ: begin
        mem_re = 1'b1;
        if (mode_r == MODE_TAKE_HEAD) begin
          raddr = head_r;
        end else begin
          raddr = head_r + IDX_W'(count_r - 1'b1);
        end
      end
      OP_SWEEP: begin
        // entries after the match move down one slot
        mem_re = sweep_rd;
        mem_we = rd_vld_r && found_r;
      end
      default: begin
      end
    endcase
  end

  // entry store, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= entry_mem[raddr];
    end
  end

  // store bookkeeping
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    closed_nxt = closed_r;
    case (cmd.op)
      OP_APPEND: begin
        count_nxt = count_r + 1'b1;
      end
      OP_TAKE: begin
        count_nxt = count_r - 1'b1;
        if (mode_r == MODE_TAKE_HEAD) begin
          head_nxt = head_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found_r) begin
          count_nxt = count_r - 1'b1;
        end
      end
      OP_CLOSE: begin
        count_nxt  = '0;
        head_nxt   = '0;
        closed_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      closed_r    <= 1'b0;
      max_r       <= CNT_W'(DEPTH);
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      closed_r <= closed_nxt;
      if (cfg_we) begin
        max_r <= cfg_max;
      end
      // sweep pointer and match flag
      if (cmd.req_load) begin
        ptr_r    <= '0;
        rd_vld_r <= 1'b0;
        found_r  <= 1'b0;
      end else if (cmd.op == OP_SWEEP) begin
        rd_vld_r <= sweep_rd;
        if (sweep_rd) begin
          ptr_r <= ptr_r + 1'b1;
        end
        if (rd_vld_r && !found_r && (rdata_r == word_r)) begin
          found_r <= 1'b1;
        end
      end
      // output valid
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      mode_r <= in_mode;
      word_r <= in_value;
    end
    if (sweep_rd) begin
      tag_r <= ptr_r[IDX_W-1:0];
    end
    if (cmd.res_load) begin
      out_item_r   <= (cmd.op == OP_TAKE) ? rdata_r : '0;
      out_status_r <= cmd.res_status;
      out_count_r  <= closed_nxt ? '0 : count_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

`ifndef ASSERT_OFF
  a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r && rst_n |=> closed_r)
    else $error("store reopened without reset");

  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> (count_r == '0))
    else $error("closed store holds entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> out_free)
    else $error("result loaded over a waiting item");

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_TAKE) |-> (count_r != '0))
    else $error("take from empty store");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SWEEP) |-> (ptr_r <= count_r))
    else $error("sweep pointer past count");
`endif

endmodule

### sv/bounded_deque_with_remove.sv
// channel   direction  payload                            handshake
// in_ch     in         mode, item_value                   valid/ready
// out_ch    out        item_out, status, entry_count      valid/ready
// cfg_ch    in         max_entries                        valid/ready, always ready
//
// one item at a time; ready only while the controller is idle
// append, close and refused requests: the result is loaded in the exec state after accept
// take head or tail: the exec state reads the entry store into a register, the read state loads the result
// remove: the sweep state scans the stored entries, one entry a cycle, then loads the result
// a waiting result stalls the next item before it changes count, head or closed flag; reset clears all control
module bounded_deque_with_remove (
  input logic        clk,
  input logic        rst_n,
  bdq_in_if.sink     in_ch,
  bdq_out_if.source  out_ch,
  bdq_cfg_if.sink    cfg_ch
);
  import bdq_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ctl_in_ready;

  // configuration is always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = ctl_in_ready;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_ch.mode),
    .in_value   (in_ch.item_value),
    .cfg_we     (cfg_ch.valid),
    .cfg_max    (cfg_ch.max_entries),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_item   (out_ch.item_out),
    .out_status (out_ch.status),
    .out_count  (out_ch.entry_count)
  );

endmodule
